// ----- sv/bsq_pkg.sv -----
// ============================================================================
// bsq_pkg: shared types for the bounded sorted priority queue
// Status codes, action codes, cell control word and config bus constants.
// ============================================================================
package bsq_pkg;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } t_action;

    typedef enum logic {
        CFG_HIGHEST_FIRST = 1'b0,
        CFG_MAX_ENTRIES   = 1'b1
    } t_cfg_reg;

    // config bus: registers at byte offsets 0 and 4
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int CFG_SEL_BIT = 2;

    // per-cell control word, driven by the top level every cycle
    typedef struct packed {
        logic cmp_en;
        logic highest_first;
        logic load_new;
        logic shift_fwd;
        logic shift_back;
    } t_cell_ctl;

endpackage

// ----- sv/bsq_in_if.sv -----
// ============================================================================
// bsq_in_if: request channel of the bounded sorted priority queue
// One transfer carries an action and, for inserts, a key and a tag.
// ============================================================================
interface bsq_in_if #(
    parameter int KEY_WIDTH = 32,
    parameter int TAG_WIDTH = 16
);
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic signed [KEY_WIDTH-1:0] entry_key;
    logic        [TAG_WIDTH-1:0] entry_tag;

    modport source (output valid, action, entry_key, entry_tag, input ready);
    modport sink   (input valid, action, entry_key, entry_tag, output ready);
endinterface

// ----- sv/bsq_out_if.sv -----
// ============================================================================
// bsq_out_if: result channel of the bounded sorted priority queue
// One transfer per request: status, removed entry, front/back and counts.
// ============================================================================
interface bsq_out_if #(
    parameter int KEY_WIDTH = 32,
    parameter int TAG_WIDTH = 16,
    parameter int CAPACITY  = 64
);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                        valid;
    logic                        ready;
    logic                  [1:0] status;
    logic signed [KEY_WIDTH-1:0] taken_key;
    logic        [TAG_WIDTH-1:0] taken_tag;
    logic signed [KEY_WIDTH-1:0] front_key;
    logic        [TAG_WIDTH-1:0] front_tag;
    logic signed [KEY_WIDTH-1:0] back_key;
    logic        [TAG_WIDTH-1:0] back_tag;
    logic            [CNT_W-1:0] live_count;
    logic            [CNT_W-1:0] peak_count;
    logic                        is_empty;

    modport source (output valid, status, taken_key, taken_tag, front_key, front_tag,
                    back_key, back_tag, live_count, peak_count, is_empty,
                    input ready);
    modport sink   (input valid, status, taken_key, taken_tag, front_key, front_tag,
                    back_key, back_tag, live_count, peak_count, is_empty,
                    output ready);
endinterface

// ----- sv/bsq_cell.sv -----
// ============================================================================
// bsq_cell: one slot of the sorted row
// Holds one (key, tag), flags whether a new key goes strictly ahead of it,
// and loads the new entry or a neighbor's entry when the row moves.
// ============================================================================
module bsq_cell #(
    parameter int KEY_WIDTH = 32,
    parameter int TAG_WIDTH = 16,
    parameter int CNT_W     = 7,
    parameter int INDEX     = 0
) (
    input  logic                        i_clk,
    input  bsq_pkg::t_cell_ctl          i_ctl,
    input  logic            [CNT_W-1:0] i_count,
    input  logic signed [KEY_WIDTH-1:0] i_new_key,
    input  logic        [TAG_WIDTH-1:0] i_new_tag,
    input  logic signed [KEY_WIDTH-1:0] i_prev_key,
    input  logic        [TAG_WIDTH-1:0] i_prev_tag,
    input  logic signed [KEY_WIDTH-1:0] i_next_key,
    input  logic        [TAG_WIDTH-1:0] i_next_tag,
    output logic signed [KEY_WIDTH-1:0] o_key,
    output logic        [TAG_WIDTH-1:0] o_tag,
    output logic                        o_before
);

    logic signed [KEY_WIDTH-1:0] r_key;
    logic        [TAG_WIDTH-1:0] r_tag;
    logic                        r_before;
    logic                        w_held;
    logic                        w_ahead;

    assign w_held  = CNT_W'(INDEX) < i_count;
    assign w_ahead = i_ctl.highest_first ? (i_new_key > r_key) : (i_new_key < r_key);

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_before <= w_held && w_ahead;
        end
        if (i_ctl.load_new) begin
            r_key <= i_new_key;
            r_tag <= i_new_tag;
        end else if (i_ctl.shift_fwd) begin
            r_key <= i_prev_key;
            r_tag <= i_prev_tag;
        end else if (i_ctl.shift_back) begin
            r_key <= i_next_key;
            r_tag <= i_next_tag;
        end
    end

    assign o_key    = r_key;
    assign o_tag    = r_tag;
    assign o_before = r_before;

endmodule

// ----- sv/bounded_sorted_priority_queue.sv -----
// ============================================================================
// bounded_sorted_priority_queue: sorted (key, tag) store in a row of cells
// Top level: request sequencing, cell control, counts, config and result reg.
// ============================================================================
// A request passes through S_CMP and S_UPD: in S_CMP every cell compares the
// incoming key against its own entry in parallel, in S_UPD the row shifts by
// one cell (right on insert, left on removal) and the result is registered. A
// new request is taken in the same cycle the previous one finishes; a result
// held by a stalled sink holds S_UPD. Entry 0 of the row is always the front;
// the back entry is tracked in its own register. Keys compare as signed values;
// equal keys keep arrival order. The user must set limit and ordering mode over
// the config port only while idle; the block itself does not enforce it.
module bounded_sorted_priority_queue #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32,
    parameter int TAG_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bsq_in_if.sink                         i_req,
    bsq_out_if.source                      o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bsq_pkg::APB_AW-1:0]     paddr,
    input  logic [bsq_pkg::APB_DW-1:0]     pwdata,
    output logic [bsq_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state r_state, n_state;

    bsq_pkg::t_action            r_action;
    logic signed [KEY_WIDTH-1:0] r_key;
    logic        [TAG_WIDTH-1:0] r_tag;
    logic            [CNT_W-1:0] r_count, n_count;
    logic            [CNT_W-1:0] r_peak;
    logic                        r_hf;
    logic            [CNT_W-1:0] r_max;
    logic signed [KEY_WIDTH-1:0] r_back_key;
    logic        [TAG_WIDTH-1:0] r_back_tag;

    logic                        r_ovalid;
    bsq_pkg::t_status            r_status, n_status;
    logic signed [KEY_WIDTH-1:0] r_taken_key, r_front_key, r_bk_key;
    logic        [TAG_WIDTH-1:0] r_taken_tag, r_front_tag, r_bk_tag;
    logic signed [KEY_WIDTH-1:0] n_front_key, n_back_key;
    logic        [TAG_WIDTH-1:0] n_front_tag, n_back_tag;

    logic signed [KEY_WIDTH-1:0] w_key [CAPACITY];
    logic        [TAG_WIDTH-1:0] w_tag [CAPACITY];
    logic         [CAPACITY-1:0] w_before;
    logic         [CAPACITY-1:0] w_lead;
    logic         [CAPACITY-1:0] w_pfx;
    bsq_pkg::t_cell_ctl          w_ctl [CAPACITY];

    logic             w_fire, w_take, w_full, w_empty, w_ins, w_rem, w_at_back, w_wr;
    logic [CNT_W-1:0] w_limit;

    // ---------------------------------------------------------------- control
    assign w_fire = (r_state == S_UPD) && (!r_ovalid || o_rsp.ready);
    assign i_req.ready = (r_state == S_IDLE) || w_fire;
    assign w_take = i_req.valid && i_req.ready;

    assign w_limit = (r_max > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : r_max;
    assign w_full  = r_count >= w_limit;
    assign w_empty = r_count == '0;
    assign w_ins   = w_fire && (r_action == bsq_pkg::ACT_INSERT) && !w_full;
    assign w_rem   = w_fire && (r_action == bsq_pkg::ACT_REMOVE) && !w_empty;
    // no held entry is outranked: the new entry lands at the back
    assign w_at_back = !(|w_before);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_take) n_state = S_CMP;
            S_CMP:   n_state = S_UPD;
            S_UPD: begin
                if (w_take) begin
                    n_state = S_CMP;
                end else if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_action <= bsq_pkg::t_action'(i_req.action);
            r_key    <= i_req.entry_key;
            r_tag    <= i_req.entry_tag;
        end
    end

    // ------------------------------------------------------------- cell row
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [KEY_WIDTH-1:0] w_pk, w_nk;
            logic        [TAG_WIDTH-1:0] w_pt, w_nt;
            logic                        w_open;

            // the slot just past the held entries is always a landing spot
            assign w_lead[gi] = w_before[gi] | (r_count == CNT_W'(gi));
            assign w_pfx[gi]  = |w_lead[gi:0];

            if (gi == 0) begin : g_first
                assign w_open = 1'b0;
                assign w_pk   = r_key;
                assign w_pt   = r_tag;
            end else begin : g_inner
                assign w_open = w_pfx[gi-1];
                assign w_pk   = w_key[gi-1];
                assign w_pt   = w_tag[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign w_nk = w_key[gi];
                assign w_nt = w_tag[gi];
            end else begin : g_notlast
                assign w_nk = w_key[gi+1];
                assign w_nt = w_tag[gi+1];
            end

            assign w_ctl[gi].cmp_en        = (r_state == S_CMP);
            assign w_ctl[gi].highest_first = r_hf;
            assign w_ctl[gi].load_new      = w_ins && w_lead[gi] && !w_open;
            assign w_ctl[gi].shift_fwd     = w_ins && w_open;
            assign w_ctl[gi].shift_back    = w_rem;

            bsq_cell #(
                .KEY_WIDTH (KEY_WIDTH),
                .TAG_WIDTH (TAG_WIDTH),
                .CNT_W     (CNT_W),
                .INDEX     (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[gi]),
                .i_count    (r_count),
                .i_new_key  (r_key),
                .i_new_tag  (r_tag),
                .i_prev_key (w_pk),
                .i_prev_tag (w_pt),
                .i_next_key (w_nk),
                .i_next_tag (w_nt),
                .o_key      (w_key[gi]),
                .o_tag      (w_tag[gi]),
                .o_before   (w_before[gi])
            );
        end
    endgenerate

    // --------------------------------------------------------- counts, back
    always_comb begin
        n_count = r_count;
        if (w_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_peak  <= '0;
        end else begin
            r_count <= n_count;
            if (n_count > r_peak) begin
                r_peak <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ins && w_at_back) begin
            r_back_key <= r_key;
            r_back_tag <= r_tag;
        end
    end

    // --------------------------------------------------------------- result
    always_comb begin
        n_status = bsq_pkg::STAT_OK;
        if (r_action == bsq_pkg::ACT_INSERT && w_full) begin
            n_status = bsq_pkg::STAT_FULL;
        end else if (r_action == bsq_pkg::ACT_REMOVE && w_empty) begin
            n_status = bsq_pkg::STAT_EMPTY;
        end

        n_front_key = w_key[0];
        n_front_tag = w_tag[0];
        n_back_key  = r_back_key;
        n_back_tag  = r_back_tag;
        if (w_ins) begin
            if (w_lead[0]) begin
                n_front_key = r_key;
                n_front_tag = r_tag;
            end
            if (w_at_back) begin
                n_back_key = r_key;
                n_back_tag = r_tag;
            end
        end else if (w_rem) begin
            n_front_key = w_key[1];
            n_front_tag = w_tag[1];
        end
        if (n_count == '0) begin
            n_front_key = '0;
            n_front_tag = '0;
            n_back_key  = '0;
            n_back_tag  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_fire) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status    <= n_status;
            r_taken_key <= w_rem ? w_key[0] : '0;
            r_taken_tag <= w_rem ? w_tag[0] : '0;
            r_front_key <= n_front_key;
            r_front_tag <= n_front_tag;
            r_bk_key    <= n_back_key;
            r_bk_tag    <= n_back_tag;
        end
    end

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.status     = r_status;
    assign o_rsp.taken_key  = r_taken_key;
    assign o_rsp.taken_tag  = r_taken_tag;
    assign o_rsp.front_key  = r_front_key;
    assign o_rsp.front_tag  = r_front_tag;
    assign o_rsp.back_key   = r_bk_key;
    assign o_rsp.back_tag   = r_bk_tag;
    // counts only move when a result is loaded, so they track the held result
    assign o_rsp.live_count = r_count;
    assign o_rsp.peak_count = r_peak;
    assign o_rsp.is_empty   = (r_count == '0);

    // --------------------------------------------------------------- config
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hf  <= 1'b0;
            r_max <= CNT_W'(CAPACITY);
        end else if (w_wr) begin
            if (bsq_pkg::t_cfg_reg'(paddr[bsq_pkg::CFG_SEL_BIT])
                    == bsq_pkg::CFG_MAX_ENTRIES) begin
                r_max <= pwdata[CNT_W-1:0];
            end else begin
                r_hf <= pwdata[0];
            end
        end
    end

    assign prdata = (bsq_pkg::t_cfg_reg'(paddr[bsq_pkg::CFG_SEL_BIT])
                     == bsq_pkg::CFG_MAX_ENTRIES)
                    ? bsq_pkg::APB_DW'(r_max) : bsq_pkg::APB_DW'(r_hf);

endmodule

// ----- sv/bsq_checker.sv -----
// ============================================================================
// bsq_checker: port-level checks for the bounded sorted priority queue
// Watches request/result transfers and the counts the results report.
// ============================================================================
module bsq_checker #(
    parameter int CNT_W = 7
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic       [1:0] i_status,
    input logic [CNT_W-1:0] i_live_count,
    input logic [CNT_W-1:0] i_peak_count
);

    logic             w_in_xfer, w_out_xfer;
    logic       [1:0] r_pend;
    logic [CNT_W-1:0] r_last_cnt, r_last_peak;

    assign w_in_xfer  = i_in_valid && i_in_ready;
    assign w_out_xfer = i_out_valid && i_out_ready;

    // requests accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_last_cnt  <= '0;
            r_last_peak <= '0;
        end else begin
            r_pend <= r_pend + 2'(w_in_xfer) - 2'(w_out_xfer);
            if (w_out_xfer) begin
                r_last_cnt  <= i_live_count;
                r_last_peak <= i_peak_count;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_live_count))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer |-> r_pend != 2'd0)
        else $error("result transfer without a pending request");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && !w_out_xfer |-> r_pend < 2'd2)
        else $error("too many requests in flight");

    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer && i_status != bsq_pkg::STAT_OK |-> i_live_count == r_last_cnt)
        else $error("rejected request changed the count");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer |-> i_peak_count >= i_live_count && i_peak_count >= r_last_peak &&
            (i_live_count == r_last_cnt ||
             i_live_count == CNT_W'(r_last_cnt + CNT_W'(1)) ||
             CNT_W'(i_live_count + CNT_W'(1)) == r_last_cnt))
        else $error("count or peak moved wrongly");

endmodule

bind bounded_sorted_priority_queue bsq_checker #(
    .CNT_W ($clog2(CAPACITY + 1))
) u_bsq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_live_count (o_rsp.live_count),
    .i_peak_count (o_rsp.peak_count)
);

// ----- tb/bounded_sorted_priority_queue_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// bounded_sorted_priority_queue_tb: self-checking bench for the sorted queue
// Drives inserts and removals over the request channel, and ordering mode and
// entry limit over the config port. It mirrors the queue contents in a model
// and compares every result transfer field by field. Both channels idle at
// random, except in one phase that runs at full rate.
// ============================================================================

typedef struct packed {
    bsq_pkg::t_status   status;
    logic signed [31:0] taken_key;
    logic        [15:0] taken_tag;
    logic signed [31:0] front_key;
    logic        [15:0] front_tag;
    logic signed [31:0] back_key;
    logic        [15:0] back_tag;
    logic         [6:0] live_count;
    logic         [6:0] peak_count;
    logic               is_empty;
} t_queue_result;

class sorted_queue_scoreboard #(int CAPACITY = 64);
    logic signed [31:0] held_keys[$];
    logic        [15:0] held_tags[$];
    logic         [6:0] peak;
    logic               highest_first;
    logic         [6:0] max_entries;
    t_queue_result      pending_results[$];
    int                 failures;

    function new();
        peak          = '0;
        highest_first = 1'b0;
        max_entries   = 7'd64;
        failures      = 0;
    endfunction

    function bit key_precedes(logic signed [31:0] a, logic signed [31:0] b);
        return highest_first ? (a > b) : (a < b);
    endfunction

    // Apply one accepted request to the mirrored queue and queue its result.
    function void note_request(bsq_pkg::t_action act, logic signed [31:0] key,
                               logic [15:0] tag);
        t_queue_result r;
        int            limit;
        int            pos;
        r        = '0;
        r.status = bsq_pkg::STAT_OK;
        limit    = (max_entries > CAPACITY) ? CAPACITY : int'(max_entries);
        if (act == bsq_pkg::ACT_INSERT) begin
            if (held_keys.size() >= limit) begin
                r.status = bsq_pkg::STAT_FULL;
            end else begin
                // new entry goes behind every held entry it does not strictly precede
                pos = held_keys.size();
                for (int i = 0; i < held_keys.size(); i++) begin
                    if (key_precedes(key, held_keys[i])) begin
                        pos = i;
                        break;
                    end
                end
                held_keys.insert(pos, key);
                held_tags.insert(pos, tag);
                if (held_keys.size() > peak) begin
                    peak = 7'(held_keys.size());
                end
            end
        end else if (held_keys.size() == 0) begin
            r.status = bsq_pkg::STAT_EMPTY;
        end else begin
            r.taken_key = held_keys.pop_front();
            r.taken_tag = held_tags.pop_front();
        end
        if (held_keys.size() > 0) begin
            r.front_key = held_keys[0];
            r.front_tag = held_tags[0];
            r.back_key  = held_keys[held_keys.size() - 1];
            r.back_tag  = held_tags[held_tags.size() - 1];
        end
        r.live_count = 7'(held_keys.size());
        r.peak_count = peak;
        r.is_empty   = (held_keys.size() == 0);
        pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
        if (got !== want) begin
            failures++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    function void check_result(t_queue_result got);
        t_queue_result want;
        if (pending_results.size() == 0) begin
            failures++;
            $error("result transfer with no request outstanding");
            return;
        end
        want = pending_results.pop_front();
        compare_field("status",     want.status,     got.status);
        compare_field("taken_key",  want.taken_key,  got.taken_key);
        compare_field("taken_tag",  want.taken_tag,  got.taken_tag);
        compare_field("front_key",  want.front_key,  got.front_key);
        compare_field("front_tag",  want.front_tag,  got.front_tag);
        compare_field("back_key",   want.back_key,   got.back_key);
        compare_field("back_tag",   want.back_tag,   got.back_tag);
        compare_field("live_count", want.live_count, got.live_count);
        compare_field("peak_count", want.peak_count, got.peak_count);
        compare_field("is_empty",   want.is_empty,   got.is_empty);
    endfunction
endclass

module bounded_sorted_priority_queue_tb;

    localparam int CLK_PERIOD     = 10;
    localparam int CAPACITY       = 64;
    localparam int KEY_W          = 32;
    localparam int TAG_W          = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 9;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [bsq_pkg::APB_AW-1:0] paddr;
    logic [bsq_pkg::APB_DW-1:0] pwdata;
    logic [bsq_pkg::APB_DW-1:0] prdata;
    logic                       pready;

    bsq_in_if  #(.KEY_WIDTH(KEY_W), .TAG_WIDTH(TAG_W)) req_if ();
    bsq_out_if #(.KEY_WIDTH(KEY_W), .TAG_WIDTH(TAG_W), .CAPACITY(CAPACITY)) rsp_if ();

    bounded_sorted_priority_queue #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_W),
        .TAG_WIDTH (TAG_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sorted_queue_scoreboard #(CAPACITY) sb;

    bit calm;
    int idle_cycles = 0;

    // random phases: mode, limit (-1 picks one at random), insert share, length
    int phase_mode[NUM_PHASES]   = '{0, 1, 0, 1, 0, 1, 0, 1, 0};
    int phase_limit[NUM_PHASES]  = '{64, 127, 64, 100, 3, 0, 1, 64, -1};
    int phase_insert[NUM_PHASES] = '{70, 75, 30, 55, 60, 50, 50, 80, 40};
    int phase_items[NUM_PHASES]  = '{150, 150, 120, 120, 100, 60, 60, 120, 120};

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        rsp_if.ready <= calm || ($urandom_range(0, 99) >= 35);
    end

    always @(posedge i_clk) begin
        t_queue_result got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.status     = bsq_pkg::t_status'(rsp_if.status);
            got.taken_key  = rsp_if.taken_key;
            got.taken_tag  = rsp_if.taken_tag;
            got.front_key  = rsp_if.front_key;
            got.front_tag  = rsp_if.front_tag;
            got.back_key   = rsp_if.back_key;
            got.back_tag   = rsp_if.back_tag;
            got.live_count = rsp_if.live_count;
            got.peak_count = rsp_if.peak_count;
            got.is_empty   = rsp_if.is_empty;
            sb.check_result(got);
        end
    end

    // stall watchdog: any transfer on either channel or the config port resets it
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic program_register(bsq_pkg::t_cfg_reg which, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bsq_pkg::APB_AW'(int'(which) << bsq_pkg::CFG_SEL_BIT);
        pwdata  <= bsq_pkg::APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (which == bsq_pkg::CFG_HIGHEST_FIRST) begin
            sb.highest_first = value[0];
        end else begin
            sb.max_entries = value[6:0];
        end
    endtask

    task automatic send_request(bsq_pkg::t_action act, logic signed [31:0] key,
                                logic [15:0] tag);
        if (!calm) begin
            while ($urandom_range(0, 99) < 35) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_if.valid     <= 1'b1;
        req_if.action    <= act;
        req_if.entry_key <= key;
        req_if.entry_tag <= tag;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(act, key, tag);
    endtask

    // Q16.16 keys: often from a narrow pool so equal keys are common
    function automatic logic signed [31:0] pick_key();
        int sel;
        int whole;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            whole = int'($urandom_range(0, 8)) - 4;
            return 32'(whole * 65536);
        end else if (sel == 4) begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return 32'($urandom);
    endfunction

    task automatic send_random(int insert_pct);
        bsq_pkg::t_action act;
        act = ($urandom_range(0, 99) < insert_pct) ? bsq_pkg::ACT_INSERT
                                                   : bsq_pkg::ACT_REMOVE;
        send_request(act, pick_key(), 16'($urandom_range(0, 65535)));
    endtask

    // every request yields one result, so idle once all results are back
    task automatic settle();
        req_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int lim;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_if.valid     = 1'b0;
        req_if.action    = bsq_pkg::ACT_INSERT;
        req_if.entry_key = '0;
        req_if.entry_tag = '0;
        calm             = 1'b0;
        sb               = new();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // removal from empty, key extremes, tag extremes, equal keys in order
        send_request(bsq_pkg::ACT_REMOVE, 32'sh1234_5678, 16'hBEEF);
        send_request(bsq_pkg::ACT_INSERT, 32'sh7FFF_FFFF, 16'hFFFF);
        send_request(bsq_pkg::ACT_INSERT, 32'sh8000_0000, 16'h0000);
        send_request(bsq_pkg::ACT_INSERT, 32'sh0000_0000, 16'h0001);
        send_request(bsq_pkg::ACT_INSERT, -32'sd1,        16'h0002);
        send_request(bsq_pkg::ACT_INSERT, 32'sh0000_0000, 16'h0003);
        send_request(bsq_pkg::ACT_INSERT, 32'sh0000_0000, 16'h0004);
        send_request(bsq_pkg::ACT_INSERT, 32'sh0000_0001, 16'hAAAA);
        send_request(bsq_pkg::ACT_REMOVE, 32'sh0000_0000, 16'h0000);
        send_request(bsq_pkg::ACT_REMOVE, 32'sh7FFF_FFFF, 16'hFFFF);
        send_request(bsq_pkg::ACT_REMOVE, 32'sh8000_0000, 16'h5555);

        // limit dropped below the held count: inserts bounce, removals still work
        settle();
        program_register(bsq_pkg::CFG_MAX_ENTRIES, 2);
        send_request(bsq_pkg::ACT_INSERT, 32'sh0001_0000, 16'h0010);
        send_request(bsq_pkg::ACT_REMOVE, 32'sh0000_0000, 16'h0000);
        send_request(bsq_pkg::ACT_INSERT, 32'sh0001_0000, 16'h0011);
        send_request(bsq_pkg::ACT_REMOVE, 32'sh0000_0000, 16'h0000);
        send_request(bsq_pkg::ACT_INSERT, 32'sh0001_0000, 16'h0012);

        // flip to highest first with entries held; limit above capacity
        settle();
        program_register(bsq_pkg::CFG_HIGHEST_FIRST, 1);
        program_register(bsq_pkg::CFG_MAX_ENTRIES, 127);
        send_request(bsq_pkg::ACT_INSERT, 32'sh0005_0000, 16'h0020);
        send_request(bsq_pkg::ACT_INSERT, -32'sh0005_0000, 16'h0021);
        send_request(bsq_pkg::ACT_INSERT, 32'sh0005_0000, 16'h0022);
        send_request(bsq_pkg::ACT_INSERT, 32'sh7FFF_FFFF, 16'h0023);
        repeat (7) send_request(bsq_pkg::ACT_REMOVE, 32'sh0000_0000, 16'h0000);

        // zero limit rejects every insert
        settle();
        program_register(bsq_pkg::CFG_MAX_ENTRIES, 0);
        send_request(bsq_pkg::ACT_INSERT, 32'sh0000_0000, 16'h0030);
        send_request(bsq_pkg::ACT_REMOVE, 32'sh0000_0000, 16'h0000);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            lim  = (phase_limit[p] < 0) ? int'($urandom_range(0, 127)) : phase_limit[p];
            calm = (p == 3);
            program_register(bsq_pkg::CFG_HIGHEST_FIRST, phase_mode[p]);
            program_register(bsq_pkg::CFG_MAX_ENTRIES, lim);
            repeat (phase_items[p]) send_random(phase_insert[p]);
        end
        calm = 1'b0;

        settle();
        repeat (10) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
